>>> design/rlv_pkg.sv
// ----------------------------------------------------------------------------
// rlv_pkg
// shared types, constants and codes of the record locate and verify block
// ----------------------------------------------------------------------------
package rlv_pkg;

    // record layout, fixed by the header format
    localparam int HEADER_BYTES      = 32;
    localparam int STORE_BYTES_DEF   = 8192;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int ID_W     = 32;
    localparam int SUM_W    = 32;
    localparam int SIZE_W   = 13;   // wanted size register
    localparam int FIELD_W  = 16;   // size and magic fields of a header
    localparam int IDX_W    = 13;   // byte index inside header or data
    localparam int SKIP_W   = 17;   // rest of header plus a 16-bit data size
    localparam int STATUS_W = 3;
    localparam int OFF_W    = 13;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [FIELD_W-1:0] REC_MAGIC = 16'hfa3d;
    localparam logic [SUM_W-1:0]   SUM_ADD   = 32'h003a7719;

    // header bytes left after the size field
    localparam logic [SKIP_W-1:0] HDR_REST = SKIP_W'(HEADER_BYTES - 12);

    // header byte positions
    localparam logic [4:0] HB_MAGIC_HI = 5'd9;
    localparam logic [4:0] HB_SIZE_HI  = 5'd11;
    localparam logic [4:0] HB_LAST     = 5'd31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WANTED_ID   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WANTED_SIZE = 1'b1;

    typedef enum logic [1:0] {
        PH_DONE,
        PH_HEADER,
        PH_DATA,
        PH_SKIP
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 3'd0,
        ST_HDR_BAD  = 3'd1,
        ST_DATA_BAD = 3'd2,
        ST_FREE     = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

endpackage

>>> design/rlv_byte_if.sv
// ----------------------------------------------------------------------------
// rlv_byte_if
// flash byte stream channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface rlv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] flash_byte;
    logic       scan_start;

    modport source (output valid, output flash_byte, output scan_start, input ready);
    modport sink   (input valid, input flash_byte, input scan_start, output ready);
endinterface

>>> design/rlv_result_if.sv
// ----------------------------------------------------------------------------
// rlv_result_if
// search result channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface rlv_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [12:0] offset;

    modport source (output valid, output status, output offset, input ready);
    modport sink   (input valid, input status, input offset, output ready);
endinterface

>>> design/rlv_sum_step.sv
// ----------------------------------------------------------------------------
// rlv_sum_step
// one step of the rolling record checksum
// ----------------------------------------------------------------------------
module rlv_sum_step
    import rlv_pkg::*;
(
    input  logic [SUM_W-1:0]  sum,
    input  logic [BYTE_W-1:0] data,
    input  logic [IDX_W-1:0]  idx,
    output logic [SUM_W-1:0]  sum_new
);

    logic [SUM_W-1:0] term;
    logic [SUM_W-1:0] term_sh;

    assign term = SUM_W'(data) + SUM_W'(idx) + SUM_ADD;

    // shift is idx mod 128; 32 and above gives zero
    assign term_sh = (idx[6:5] == 2'b00) ? (term << idx[4:0]) : '0;

    assign sum_new = sum ^ (sum << 3) ^ (sum >> 1) ^ term_sh;

endmodule

>>> design/record_locate_verify.sv
// ----------------------------------------------------------------------------
// record_locate_verify
// scans a flash image for a record by id and size and verifies its checksums
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  -------   ---  ---------------  ---------------------------------
//  flash     in   valid / ready    flash_byte[7:0], scan_start
//  report    out  valid / ready    status[2:0], offset[12:0]
//  cfg       in   cfg_we           cfg_index[0], cfg_data[31:0]
//
//  one item per cycle while the report register is free or read; each byte is
//  registered in the input stage, its result, if any, in the report register
//  all work on a byte is one checksum step plus field compares, between the
//  input stage and the report register
//  reset clears the scan to done, awaiting a byte flagged scan_start
//  the input stage holds any byte while the report register is full and
//  unread; flash.ready drops only then
//
module record_locate_verify
    import rlv_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    rlv_byte_if.sink             flash,
    rlv_result_if.source         report
);

    // record offsets stay below the store size
    localparam int OW = $clog2(STORE_BYTES);
    // room for offset + header + 16-bit size + wanted size
    localparam int NW = ((OW > FIELD_W) ? OW : FIELD_W) + 2;
    localparam logic [NW-1:0] LIMIT = NW'(STORE_BYTES - HEADER_BYTES);

    // configuration
    logic [ID_W-1:0]   wanted_id_reg;
    logic [SIZE_W-1:0] wanted_size_reg;

    // input stage
    logic              stage_valid_reg;
    logic [BYTE_W-1:0] stage_byte_reg;
    logic              stage_start_reg;

    // scan state
    phase_t             phase_reg,  phase_next;
    logic [OW-1:0]      rec_off_reg, rec_off_next;
    logic [ID_W-1:0]    id_reg,     id_next;
    logic [SUM_W-1:0]   chk_reg,    chk_next;
    logic [FIELD_W-1:0] magic_reg,  magic_next;
    logic [FIELD_W-1:0] size_reg,   size_next;
    logic [SUM_W-1:0]   sum_reg,    sum_next;
    logic [IDX_W-1:0]   idx_reg,    idx_next;
    logic [SKIP_W-1:0]  skip_reg,   skip_next;

    // report register
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [OFF_W-1:0]  out_off_reg;

    logic              proc_fire;
    logic              beyond0;
    logic              fresh;

    // state as seen by the current byte (cleared on a fresh scan)
    phase_t             cur_phase;
    logic [OW-1:0]      cur_off;
    logic [ID_W-1:0]    cur_id;
    logic [SUM_W-1:0]   cur_chk;
    logic [FIELD_W-1:0] cur_magic;
    logic [FIELD_W-1:0] cur_size;
    logic [SUM_W-1:0]   cur_sum;
    logic [IDX_W-1:0]   cur_idx;
    logic [4:0]         hb;

    // checksum step
    logic [BYTE_W-1:0]  sum_data;
    logic [IDX_W-1:0]   sum_idx;
    logic [SUM_W-1:0]   sum_new;

    logic [NW-1:0]      next_off;
    logic [IDX_W:0]     idx_inc;

    logic               emit;
    status_t            emit_status;
    logic [OFF_W-1:0]   emit_off;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------

    // the stage moves on when the report register can take a result
    assign proc_fire   = stage_valid_reg && (!out_valid_reg || report.ready);
    assign flash.ready = !stage_valid_reg || proc_fire;

    assign report.valid  = out_valid_reg;
    assign report.status = out_status_reg;
    assign report.offset = out_off_reg;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_id_reg   <= '0;
            wanted_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WANTED_ID:   wanted_id_reg   <= cfg_data;
                REG_WANTED_SIZE: wanted_size_reg <= cfg_data[SIZE_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (flash.ready)
        begin
            stage_valid_reg <= flash.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flash.valid && flash.ready)
        begin
            stage_byte_reg  <= flash.flash_byte;
            stage_start_reg <= flash.scan_start;
        end
    end

    // ------------------------------------------------------------------
    // per-byte work
    // ------------------------------------------------------------------

    // header at offset zero fits only if the wanted data fits after it
    assign beyond0 = NW'(wanted_size_reg) >= LIMIT;
    assign fresh   = stage_start_reg && !beyond0;

    always_comb
    begin
        cur_phase = fresh ? PH_HEADER : phase_reg;
        cur_off   = fresh ? '0 : rec_off_reg;
        cur_id    = fresh ? '0 : id_reg;
        cur_chk   = fresh ? '0 : chk_reg;
        cur_magic = fresh ? '0 : magic_reg;
        cur_size  = fresh ? '0 : size_reg;
        cur_sum   = fresh ? '0 : sum_reg;
        cur_idx   = fresh ? '0 : idx_reg;
    end

    assign hb = cur_idx[4:0];

    // stored checksum bytes count as zero in the header checksum
    always_comb
    begin
        if (cur_phase == PH_HEADER)
        begin
            sum_data = (hb inside {[5'd4:5'd7]}) ? '0 : stage_byte_reg;
            sum_idx  = IDX_W'(hb);
        end
        else
        begin
            sum_data = stage_byte_reg;
            sum_idx  = cur_idx;
        end
    end

    rlv_sum_step u_sum_step (
        .sum     (cur_sum),
        .data    (sum_data),
        .idx     (sum_idx),
        .sum_new (sum_new)
    );

    always_comb
    begin
        phase_next   = phase_reg;
        rec_off_next = rec_off_reg;
        id_next      = id_reg;
        chk_next     = chk_reg;
        magic_next   = magic_reg;
        size_next    = size_reg;
        sum_next     = sum_reg;
        idx_next     = idx_reg;
        skip_next    = skip_reg;
        emit         = 1'b0;
        emit_status  = ST_FOUND;
        emit_off     = OFF_W'(cur_off);
        next_off     = NW'(cur_off) + NW'(HEADER_BYTES) + NW'(cur_size);
        idx_inc      = {1'b0, cur_idx} + 1'b1;

        if (proc_fire)
        begin
            if (stage_start_reg && beyond0)
            begin
                // nothing fits: store full straight away
                emit        = 1'b1;
                emit_status = ST_FULL;
                emit_off    = '0;
                phase_next  = PH_DONE;
            end
            else
            begin
                case (cur_phase)
                    PH_HEADER:
                    begin
                        // collect little-endian header fields
                        id_next    = cur_id;
                        chk_next   = cur_chk;
                        magic_next = cur_magic;
                        size_next  = cur_size;
                        case (hb)
                            5'd0:    id_next[7:0]     = stage_byte_reg;
                            5'd1:    id_next[15:8]    = stage_byte_reg;
                            5'd2:    id_next[23:16]   = stage_byte_reg;
                            5'd3:    id_next[31:24]   = stage_byte_reg;
                            5'd4:    chk_next[7:0]    = stage_byte_reg;
                            5'd5:    chk_next[15:8]   = stage_byte_reg;
                            5'd6:    chk_next[23:16]  = stage_byte_reg;
                            5'd7:    chk_next[31:24]  = stage_byte_reg;
                            5'd8:    magic_next[7:0]  = stage_byte_reg;
                            5'd9:    magic_next[15:8] = stage_byte_reg;
                            5'd10:   size_next[7:0]   = stage_byte_reg;
                            5'd11:   size_next[15:8]  = stage_byte_reg;
                            default: ;
                        endcase
                        next_off     = NW'(cur_off) + NW'(HEADER_BYTES) + NW'(size_next);
                        sum_next     = sum_new;
                        idx_next     = IDX_W'(hb) + 1'b1;
                        rec_off_next = cur_off;
                        phase_next   = PH_HEADER;

                        if (hb == HB_MAGIC_HI && magic_next != REC_MAGIC)
                        begin
                            // no record here: free slot
                            emit        = 1'b1;
                            emit_status = ST_FREE;
                            phase_next  = PH_DONE;
                        end
                        else if (hb == HB_SIZE_HI &&
                                 (id_next != wanted_id_reg ||
                                  size_next != FIELD_W'(wanted_size_reg)))
                        begin
                            if (next_off + NW'(wanted_size_reg) >= LIMIT)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_FULL;
                                emit_off    = '0;
                                phase_next  = PH_DONE;
                            end
                            else
                            begin
                                // step over the rest of this record
                                rec_off_next = next_off[OW-1:0];
                                skip_next    = HDR_REST + SKIP_W'(size_next);
                                phase_next   = PH_SKIP;
                            end
                        end
                        else if (hb == HB_LAST)
                        begin
                            if (chk_next[7:0] != sum_new[7:0])
                            begin
                                emit        = 1'b1;
                                emit_status = ST_HDR_BAD;
                                phase_next  = PH_DONE;
                            end
                            else
                            begin
                                sum_next = '0;
                                idx_next = '0;
                                if (wanted_size_reg == '0)
                                begin
                                    // empty data: upper checksum bits must be zero
                                    emit        = 1'b1;
                                    emit_status = (chk_next[31:8] == '0) ?
                                                  ST_FOUND : ST_DATA_BAD;
                                    phase_next  = PH_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_DATA;
                                end
                            end
                        end
                    end

                    PH_DATA:
                    begin
                        sum_next = sum_new;
                        idx_next = idx_inc[IDX_W-1:0];
                        if (idx_inc >= (IDX_W+1)'(wanted_size_reg))
                        begin
                            emit        = 1'b1;
                            emit_status = (chk_reg[31:8] == sum_new[31:8]) ?
                                          ST_FOUND : ST_DATA_BAD;
                            phase_next  = PH_DONE;
                        end
                    end

                    PH_SKIP:
                    begin
                        skip_next = skip_reg - 1'b1;
                        if (skip_reg == SKIP_W'(1))
                        begin
                            // next header starts with the following byte
                            phase_next = PH_HEADER;
                            id_next    = '0;
                            chk_next   = '0;
                            magic_next = '0;
                            size_next  = '0;
                            sum_next   = '0;
                            idx_next   = '0;
                        end
                    end

                    default:
                    begin
                        // done and no scan start: byte is dropped
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_DONE;
            rec_off_reg <= '0;
            id_reg      <= '0;
            chk_reg     <= '0;
            magic_reg   <= '0;
            size_reg    <= '0;
            sum_reg     <= '0;
            idx_reg     <= '0;
            skip_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            rec_off_reg <= rec_off_next;
            id_reg      <= id_next;
            chk_reg     <= chk_next;
            magic_reg   <= magic_next;
            size_reg    <= size_next;
            sum_reg     <= sum_next;
            idx_reg     <= idx_next;
            skip_reg    <= skip_next;
        end
    end

    // ------------------------------------------------------------------
    // report register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_off_reg    <= emit_off;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // every result ends the scan
    a_emit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (phase_reg == PH_DONE && out_valid_reg))
        else $error("result issued without ending the scan");

    // header byte index never runs past the header
    a_header_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (idx_reg < IDX_W'(HEADER_BYTES)))
        else $error("header index out of range");

    // a skip always has bytes left to drop
    a_skip_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (skip_reg != '0))
        else $error("skip phase with zero count");

    // a held input byte stays until it is processed
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !proc_fire) |=> stage_valid_reg)
        else $error("input stage lost a byte");

endmodule
